[sv/glucose_trend_forecast_risk_core_defines.svh]
// assertion macros shared by the glucose forecast checker
`ifndef GLUCOSE_TREND_FORECAST_RISK_CORE_DEFINES_SVH
`define GLUCOSE_TREND_FORECAST_RISK_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define GTFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define GTFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gtfr_pkg.sv]
// shared constants, types and tables of the glucose forecast block
package gtfr_pkg;

    localparam int TREND_WINDOW = 5;
    localparam int TREND_W      = 13;
    localparam int SUM_W        = TREND_W + $clog2(TREND_WINDOW);
    localparam int SLOT_W       = (TREND_WINDOW > 1) ? $clog2(TREND_WINDOW) : 1;
    localparam int CNT_W        = $clog2(TREND_WINDOW + 2);
    localparam int NSEL_W       = 5;

    // scaled trend magnitude, prediction accumulator
    localparam int X_W          = SUM_W + 5;
    localparam int P_W          = X_W + 2;

    // shared multiplier operands
    localparam int MUL_A_W      = (X_W > 17) ? X_W : 17;
    localparam int MUL_B_W      = 29;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;

    localparam int IN_W         = 64;
    localparam int OUT_W        = 48;

    // reciprocal constants: floor(x / d) = (x * K) >> S over the used ranges
    localparam int RECIP_SHIFT  = 28;
    localparam int D100_SHIFT   = 23;
    localparam int D1000_SHIFT  = 26;
    localparam int D10_SHIFT    = 11;
    localparam logic [MUL_B_W-1:0] D100_K  = MUL_B_W'(83887);
    localparam logic [MUL_B_W-1:0] D1000_K = MUL_B_W'(67109);
    localparam logic [MUL_B_W-1:0] D10_K   = MUL_B_W'(205);

    localparam logic [15:0] PRED_MIN = 16'd3000;
    localparam logic [15:0] PRED_MAX = 16'd40000;

    localparam logic [6:0] HYPO_FULL  = 7'd95;
    localparam logic [6:0] HYPER_FULL = 7'd90;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_M30,
        ST_M60,
        ST_PRED,
        ST_D30,
        ST_D60,
        ST_DHYPO,
        ST_DHYPER,
        ST_FUSE,
        ST_F10,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MOP_Q30,
        MOP_Q60,
        MOP_O30,
        MOP_O60,
        MOP_HYPO,
        MOP_HYPER,
        MOP_FUSED
    } t_mop;

    typedef enum logic [2:0] {
        ADV_NONE,
        ADV_MONITOR,
        ADV_SNACK,
        ADV_INSULIN,
        ADV_CHECK
    } t_advice;

    typedef enum logic [1:0] {
        RC_ZERO,
        RC_FULL,
        RC_DIV
    } t_rcase;

    typedef struct packed {
        logic load;
        logic scale;
        logic mul_en;
        t_mop mop;
        logic cap_q30;
        logic pred;
        logic risk;
        logic cap_o30;
        logic cap_o60;
        logic cap_hypo;
        logic cap_hyper;
        logic emit;
    } t_ctrl;

    // ceil(2^28 / n) for the window average
    function automatic logic [MUL_B_W-1:0] recip(input logic [NSEL_W-1:0] n);
        logic [MUL_B_W-1:0] k;
        unique case (n)
            5'd1:    k = MUL_B_W'(268435456);
            5'd2:    k = MUL_B_W'(134217728);
            5'd3:    k = MUL_B_W'(89478486);
            5'd4:    k = MUL_B_W'(67108864);
            5'd5:    k = MUL_B_W'(53687092);
            5'd6:    k = MUL_B_W'(44739243);
            5'd7:    k = MUL_B_W'(38347923);
            5'd8:    k = MUL_B_W'(33554432);
            5'd9:    k = MUL_B_W'(29826162);
            5'd10:   k = MUL_B_W'(26843546);
            5'd11:   k = MUL_B_W'(24403224);
            5'd12:   k = MUL_B_W'(22369622);
            5'd13:   k = MUL_B_W'(20648882);
            5'd14:   k = MUL_B_W'(19173962);
            5'd15:   k = MUL_B_W'(17895698);
            5'd16:   k = MUL_B_W'(16777216);
            default: k = MUL_B_W'(134217728);
        endcase
        return k;
    endfunction

endpackage

[sv/glucose_trend_forecast_risk_core.sv]
// glucose trend forecast and risk scoring, top level with datapath
// tvalid is registered and rises after ST_OUT emits; ST_OUT waits until the output is free
// one reading is in work at a time, with the sequencer stepping one shared
// multiplier through the window average, the predictions and the risk divisions
// a result waits in the output register; the next reading is taken meanwhile
// reset (synchronous, active low) clears sequencer, window sum, count, slot and tvalid
module glucose_trend_forecast_risk_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // glucose_mgdl, trend_centi, insulin_centi_units, carbs_deci_grams,
    // heart_rate, activity_level, zero pad
    input  logic [gtfr_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // glucose_in_30, glucose_in_60, hypo_risk, hyper_risk, fused_risk,
    // advice_code, zero pad
    output logic [gtfr_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int P_W = gtfr_pkg::P_W;
    localparam int X_W = gtfr_pkg::X_W;
    localparam logic signed [P_W-1:0] P_LO = P_W'(3000);
    localparam logic signed [P_W-1:0] P_HI = P_W'(40000);

    gtfr_pkg::t_ctrl w_ctrl;
    logic            w_out_free;

    logic signed [gtfr_pkg::SUM_W-1:0] w_sum;
    logic [gtfr_pkg::NSEL_W-1:0]       w_n;
    logic                              w_first;
    logic [gtfr_pkg::PROD_W-1:0]       w_prod;
    logic [gtfr_pkg::MUL_A_W-1:0]      w_mul_a;
    logic [gtfr_pkg::MUL_B_W-1:0]      w_mul_b;

    // latched reading
    logic [9:0]  r_g;
    logic [12:0] r_iob;
    logic [10:0] r_cob;
    logic [7:0]  r_act;

    // working registers
    logic [X_W-1:0]                r_x30, r_x60, r_q30;
    logic                          r_neg, r_first;
    logic [gtfr_pkg::MUL_B_W-1:0]  r_k;
    logic signed [P_W-1:0]         r_base30, r_base60;
    logic [15:0]                   r_p30, r_p60;
    gtfr_pkg::t_rcase              r_hycase, r_hrcase;
    logic [16:0]                   r_hynum, r_hrnum;
    logic [9:0]                    r_o30, r_o60;
    logic [6:0]                    r_hypo, r_hyper;

    logic [gtfr_pkg::OUT_W-1:0]    r_out_data;
    logic                          r_out_valid, n_out_valid;

    // combinational helpers
    logic [gtfr_pkg::SUM_W-1:0] w_mag;
    logic signed [P_W-1:0]      w_gx, w_ix, w_cx, w_ax, w_g100, w_i9, w_c10, w_a30;
    logic signed [P_W-1:0]      w_s30, w_s60;
    logic [X_W-1:0]             w_q60;
    logic [15:0]                w_c30, w_c60;
    logic [17:0]                w_p30x, w_p60x;
    gtfr_pkg::t_rcase           w_hycase, w_hrcase;
    logic [17:0]                w_hynum, w_hrnum;
    logic [6:0]                 w_fused;
    gtfr_pkg::t_advice          w_advice;

    assign w_out_free = !r_out_valid || m_axis_tready;

    gtfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_ready    (s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    gtfr_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ctrl.load),
        .i_trend (s_axis_tdata[22:10]),
        .o_sum   (w_sum),
        .o_n     (w_n),
        .o_first (w_first)
    );

    gtfr_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // operand selection for the shared multiplier
    always_comb begin
        unique case (w_ctrl.mop)
            gtfr_pkg::MOP_Q30: begin
                w_mul_a = gtfr_pkg::MUL_A_W'(r_x30);
                w_mul_b = r_k;
            end
            gtfr_pkg::MOP_Q60: begin
                w_mul_a = gtfr_pkg::MUL_A_W'(r_x60);
                w_mul_b = r_k;
            end
            gtfr_pkg::MOP_O30: begin
                w_mul_a = gtfr_pkg::MUL_A_W'(r_p30);
                w_mul_b = gtfr_pkg::D100_K;
            end
            gtfr_pkg::MOP_O60: begin
                w_mul_a = gtfr_pkg::MUL_A_W'(r_p60);
                w_mul_b = gtfr_pkg::D100_K;
            end
            gtfr_pkg::MOP_HYPO: begin
                w_mul_a = gtfr_pkg::MUL_A_W'(r_hynum);
                w_mul_b = gtfr_pkg::D100_K;
            end
            gtfr_pkg::MOP_HYPER: begin
                w_mul_a = gtfr_pkg::MUL_A_W'(r_hrnum);
                w_mul_b = gtfr_pkg::D1000_K;
            end
            gtfr_pkg::MOP_FUSED: begin
                w_mul_a = gtfr_pkg::MUL_A_W'({r_hyper, 3'b000});
                w_mul_b = gtfr_pkg::D10_K;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // scale step: trend magnitude times 30 and 60, fixed terms of both predictions
    always_comb begin
        w_mag  = w_sum[gtfr_pkg::SUM_W-1] ? gtfr_pkg::SUM_W'(-w_sum)
                                          : gtfr_pkg::SUM_W'(w_sum);
        w_gx   = P_W'(r_g);
        w_ix   = P_W'(r_iob);
        w_cx   = P_W'(r_cob);
        w_ax   = P_W'(r_act);
        w_g100 = (w_gx <<< 6) + (w_gx <<< 5) + (w_gx <<< 2);
        w_i9   = (w_ix <<< 3) + w_ix;
        w_c10  = (w_cx <<< 3) + (w_cx <<< 1);
        w_a30  = (w_ax <<< 5) - (w_ax <<< 1);
    end

    // prediction step: signed average term, then clamp
    always_comb begin
        w_q60 = w_prod[gtfr_pkg::RECIP_SHIFT +: X_W];
        w_s30 = r_neg ? (r_base30 - P_W'(r_q30)) : (r_base30 + P_W'(r_q30));
        w_s60 = r_neg ? (r_base60 - P_W'(w_q60)) : (r_base60 + P_W'(w_q60));
        if (w_s30 < P_LO)      w_c30 = gtfr_pkg::PRED_MIN;
        else if (w_s30 > P_HI) w_c30 = gtfr_pkg::PRED_MAX;
        else                   w_c30 = w_s30[15:0];
        if (w_s60 < P_LO)      w_c60 = gtfr_pkg::PRED_MIN;
        else if (w_s60 > P_HI) w_c60 = gtfr_pkg::PRED_MAX;
        else                   w_c60 = w_s60[15:0];
    end

    // piecewise risk bands, numerators all kept non-negative
    always_comb begin
        w_p30x = {2'b00, r_p30};
        w_p60x = {2'b00, r_p60};
        w_hynum = '0;
        w_hrnum = '0;
        priority if (r_p30 < 16'd7000) begin
            w_hycase = gtfr_pkg::RC_FULL;
        end else if (r_p30 < 16'd8000) begin
            w_hycase = gtfr_pkg::RC_DIV;
            w_hynum  = 18'd65000 - (w_p30x << 3);
        end else if (r_p30 < 16'd9000) begin
            w_hycase = gtfr_pkg::RC_DIV;
            w_hynum  = 18'd27000 - ((w_p30x << 1) + w_p30x);
        end else begin
            w_hycase = gtfr_pkg::RC_ZERO;
        end
        // lower band scaled by ten so both bands share the divide by 1000
        priority if (r_p60 > 16'd25000) begin
            w_hrcase = gtfr_pkg::RC_FULL;
        end else if (r_p60 > 16'd18000) begin
            w_hrcase = gtfr_pkg::RC_DIV;
            w_hrnum  = (w_p60x << 3) - 18'd120000;
        end else if (r_p60 > 16'd16000) begin
            w_hrcase = gtfr_pkg::RC_DIV;
            w_hrnum  = (w_p60x << 3) + (w_p60x << 1) - 18'd160000;
        end else begin
            w_hrcase = gtfr_pkg::RC_ZERO;
        end
    end

    // fused score and advice
    always_comb begin
        priority if (r_hypo > 7'd50)  w_fused = r_hypo;
        else if (r_hyper > 7'd50)     w_fused = w_prod[gtfr_pkg::D10_SHIFT +: 7];
        else if (r_g < 10'd70)        w_fused = 7'd80;
        else if (r_g < 10'd80)        w_fused = 7'd40;
        else if (r_g > 10'd250)       w_fused = 7'd70;
        else if (r_g > 10'd180)       w_fused = 7'd30;
        else                          w_fused = 7'd10;
        priority if (r_hypo > 7'd70)  w_advice = gtfr_pkg::ADV_SNACK;
        else if (r_hyper > 7'd60)     w_advice = gtfr_pkg::ADV_INSULIN;
        else if (w_fused > 7'd50)     w_advice = gtfr_pkg::ADV_CHECK;
        else if (w_fused > 7'd20)     w_advice = gtfr_pkg::ADV_MONITOR;
        else                          w_advice = gtfr_pkg::ADV_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_g   <= s_axis_tdata[9:0];
            r_iob <= s_axis_tdata[35:23];
            r_cob <= s_axis_tdata[46:36];
            // activity only counts with a known heart rate
            r_act <= (s_axis_tdata[54:47] != 8'd0) ? s_axis_tdata[62:55] : 8'd0;
        end
        if (w_ctrl.scale) begin
            r_x30    <= (X_W'(w_mag) << 5) - (X_W'(w_mag) << 1);
            r_x60    <= (X_W'(w_mag) << 6) - (X_W'(w_mag) << 2);
            r_neg    <= w_sum[gtfr_pkg::SUM_W-1];
            r_k      <= gtfr_pkg::recip(w_n);
            r_first  <= w_first;
            r_base30 <= w_g100 - (w_i9 >>> 2) + w_c10 - w_a30;
            r_base60 <= w_g100 - w_i9 + (w_c10 <<< 1) - (w_a30 <<< 1);
        end
        if (w_ctrl.cap_q30) begin
            r_q30 <= w_prod[gtfr_pkg::RECIP_SHIFT +: X_W];
        end
        if (w_ctrl.pred) begin
            r_p30 <= w_c30;
            r_p60 <= w_c60;
        end
        if (w_ctrl.risk) begin
            r_hycase <= w_hycase;
            r_hrcase <= w_hrcase;
            r_hynum  <= w_hynum[16:0];
            r_hrnum  <= w_hrnum[16:0];
        end
        if (w_ctrl.cap_o30) begin
            r_o30 <= w_prod[gtfr_pkg::D100_SHIFT +: 10];
        end
        if (w_ctrl.cap_o60) begin
            r_o60 <= w_prod[gtfr_pkg::D100_SHIFT +: 10];
        end
        if (w_ctrl.cap_hypo) begin
            unique case (r_hycase)
                gtfr_pkg::RC_FULL: r_hypo <= gtfr_pkg::HYPO_FULL;
                gtfr_pkg::RC_DIV:  r_hypo <= w_prod[gtfr_pkg::D100_SHIFT +: 7];
                default:           r_hypo <= 7'd0;
            endcase
        end
        if (w_ctrl.cap_hyper) begin
            unique case (r_hrcase)
                gtfr_pkg::RC_FULL: r_hyper <= gtfr_pkg::HYPER_FULL;
                gtfr_pkg::RC_DIV:  r_hyper <= w_prod[gtfr_pkg::D1000_SHIFT +: 7];
                default:           r_hyper <= 7'd0;
            endcase
        end
        if (w_ctrl.emit) begin
            // a single reading so far: echo it, no risk
            if (r_first) begin
                r_out_data <= {4'd0, gtfr_pkg::ADV_NONE, 7'd0, 7'd0, 7'd0, r_g, r_g};
            end else begin
                r_out_data <= {4'd0, w_advice, w_fused, r_hyper, r_hypo, r_o60, r_o30};
            end
        end
    end

    always_comb begin
        if (w_ctrl.emit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[sv/gtfr_window.sv]
// trend window with running sum, reading count and write slot
module gtfr_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic signed [gtfr_pkg::TREND_W-1:0] i_trend,
    output logic signed [gtfr_pkg::SUM_W-1:0]   o_sum,
    output logic [gtfr_pkg::NSEL_W-1:0]         o_n,
    output logic                              o_first
);

    logic signed [gtfr_pkg::TREND_W-1:0] r_win [gtfr_pkg::TREND_WINDOW];
    logic signed [gtfr_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [gtfr_pkg::SLOT_W-1:0]         r_slot, n_slot;
    logic [gtfr_pkg::CNT_W-1:0]          r_seen, n_seen;
    logic signed [gtfr_pkg::TREND_W-1:0] w_evict;

    always_comb begin
        // a slot not yet written counts as zero
        if (r_seen >= gtfr_pkg::CNT_W'(gtfr_pkg::TREND_WINDOW)) begin
            w_evict = r_win[r_slot];
        end else begin
            w_evict = '0;
        end
        n_sum = r_sum - gtfr_pkg::SUM_W'(w_evict) + gtfr_pkg::SUM_W'(i_trend);
        if (r_slot == gtfr_pkg::SLOT_W'(gtfr_pkg::TREND_WINDOW - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + 1'b1;
        end
        if (r_seen < gtfr_pkg::CNT_W'(gtfr_pkg::TREND_WINDOW + 1)) begin
            n_seen = r_seen + 1'b1;
        end else begin
            n_seen = r_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_slot <= '0;
            r_seen <= '0;
        end else if (i_en) begin
            r_sum  <= n_sum;
            r_slot <= n_slot;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_win[r_slot] <= i_trend;
        end
    end

    always_comb begin
        if (r_seen < gtfr_pkg::CNT_W'(gtfr_pkg::TREND_WINDOW)) begin
            o_n = gtfr_pkg::NSEL_W'(r_seen);
        end else begin
            o_n = gtfr_pkg::NSEL_W'(gtfr_pkg::TREND_WINDOW);
        end
    end

    assign o_sum   = r_sum;
    assign o_first = (r_seen < gtfr_pkg::CNT_W'(2));

endmodule

[sv/gtfr_mul.sv]
// shared multiplier with registered product, held while not enabled
module gtfr_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [gtfr_pkg::MUL_A_W-1:0]  i_a,
    input  logic [gtfr_pkg::MUL_B_W-1:0]  i_b,
    output logic [gtfr_pkg::PROD_W-1:0]   o_prod
);

    logic [gtfr_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= gtfr_pkg::PROD_W'(i_a) * gtfr_pkg::PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

[sv/gtfr_ctrl.sv]
// sequencer that steps one reading through the shared multiplier
module gtfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    output logic             o_ready,
    output gtfr_pkg::t_ctrl  o_ctrl
);

    gtfr_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtfr_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = gtfr_pkg::ST_SCALE;
            end
            gtfr_pkg::ST_SCALE:  n_state = gtfr_pkg::ST_M30;
            gtfr_pkg::ST_M30:    n_state = gtfr_pkg::ST_M60;
            gtfr_pkg::ST_M60:    n_state = gtfr_pkg::ST_PRED;
            gtfr_pkg::ST_PRED:   n_state = gtfr_pkg::ST_D30;
            gtfr_pkg::ST_D30:    n_state = gtfr_pkg::ST_D60;
            gtfr_pkg::ST_D60:    n_state = gtfr_pkg::ST_DHYPO;
            gtfr_pkg::ST_DHYPO:  n_state = gtfr_pkg::ST_DHYPER;
            gtfr_pkg::ST_DHYPER: n_state = gtfr_pkg::ST_FUSE;
            gtfr_pkg::ST_FUSE:   n_state = gtfr_pkg::ST_F10;
            gtfr_pkg::ST_F10:    n_state = gtfr_pkg::ST_OUT;
            gtfr_pkg::ST_OUT: begin
                if (i_out_free) n_state = gtfr_pkg::ST_IDLE;
            end
            default:             n_state = gtfr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtfr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctrl     = '0;
        o_ctrl.mop = gtfr_pkg::MOP_Q30;
        o_ready    = 1'b0;
        unique case (r_state)
            gtfr_pkg::ST_IDLE: begin
                o_ready     = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            gtfr_pkg::ST_SCALE: o_ctrl.scale = 1'b1;
            gtfr_pkg::ST_M30: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = gtfr_pkg::MOP_Q30;
            end
            gtfr_pkg::ST_M60: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mop     = gtfr_pkg::MOP_Q60;
                o_ctrl.cap_q30 = 1'b1;
            end
            gtfr_pkg::ST_PRED: o_ctrl.pred = 1'b1;
            gtfr_pkg::ST_D30: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = gtfr_pkg::MOP_O30;
                o_ctrl.risk   = 1'b1;
            end
            gtfr_pkg::ST_D60: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mop     = gtfr_pkg::MOP_O60;
                o_ctrl.cap_o30 = 1'b1;
            end
            gtfr_pkg::ST_DHYPO: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mop     = gtfr_pkg::MOP_HYPO;
                o_ctrl.cap_o60 = 1'b1;
            end
            gtfr_pkg::ST_DHYPER: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mop      = gtfr_pkg::MOP_HYPER;
                o_ctrl.cap_hypo = 1'b1;
            end
            gtfr_pkg::ST_FUSE: o_ctrl.cap_hyper = 1'b1;
            gtfr_pkg::ST_F10: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = gtfr_pkg::MOP_FUSED;
            end
            gtfr_pkg::ST_OUT: o_ctrl.emit = i_out_free;
            default: ;
        endcase
    end

endmodule

[sv/gtfr_checker.sv]
// port-level checks on the glucose forecast block, bound to the top level
`include "glucose_trend_forecast_risk_core_defines.svh"

module gtfr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [gtfr_pkg::IN_W-1:0]   s_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [gtfr_pkg::OUT_W-1:0]  m_axis_tdata
);

    logic w_in_zero_pad;

    // spare input bit is not part of any field
    assign w_in_zero_pad = (s_axis_tdata[63] == 1'b0) || !s_axis_tdata[63];

    `GTFR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    `GTFR_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready && w_in_zero_pad, !s_axis_tready, "ready again straight after an input beat")

    `GTFR_ASSERT_NOW(a_risk_range, m_axis_tvalid, (m_axis_tdata[26:20] <= gtfr_pkg::HYPO_FULL) && (m_axis_tdata[33:27] <= gtfr_pkg::HYPER_FULL) && (m_axis_tdata[40:34] <= gtfr_pkg::HYPO_FULL), "risk field out of range")

    `GTFR_ASSERT_NOW(a_advice_range, m_axis_tvalid, (m_axis_tdata[43:41] <= gtfr_pkg::ADV_CHECK) && (m_axis_tdata[47:44] == 4'd0), "advice code or pad bits invalid")

endmodule

bind glucose_trend_forecast_risk_core gtfr_checker u_gtfr_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the glucose trend forecast and risk core
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [9:0]         glucose;
        logic signed [12:0] trend;
        logic [12:0]        insulin;
        logic [10:0]        carbs;
        logic [7:0]         heart;
        logic [7:0]         activity;
    } t_reading;

    typedef struct {
        logic [9:0]        in30;
        logic [9:0]        in60;
        logic [6:0]        hypo;
        logic [6:0]        hyper;
        logic [6:0]        fused;
        gtfr_pkg::t_advice advice;
    } t_forecast;

    typedef struct {
        t_reading  rd;
        bit        typed;
        t_forecast want;
    } t_stim_row;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int SETTLE_CYCLES = 40;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // glucose_mgdl, trend_centi, insulin_centi_units, carbs_deci_grams,
    // heart_rate, activity_level, zero pad
    logic [gtfr_pkg::IN_W-1:0]  s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // glucose_in_30, glucose_in_60, hypo_risk, hyper_risk, fused_risk,
    // advice_code, zero pad
    logic [gtfr_pkg::OUT_W-1:0] m_axis_tdata;

    // forecast state mirrored from the block
    int trend_hist[gtfr_pkg::TREND_WINDOW] = '{default: 0};
    int trend_total = 0;
    int readings = 0;
    int hist_slot = 0;

    t_forecast forecast_q[$];
    t_stim_row directed_rows[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_by_phase[4] = '{0, 60, 0, 16};
    int stall_by_phase[4] = '{0, 0, 60, 16};

    glucose_trend_forecast_risk_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [gtfr_pkg::IN_W-1:0] pack_reading(input t_reading r);
        return {1'b0, r.activity, r.heart, r.carbs, r.insulin, r.trend, r.glucose};
    endfunction

    function automatic t_forecast unpack_forecast(input logic [gtfr_pkg::OUT_W-1:0] d);
        t_forecast f;
        f.in30   = d[9:0];
        f.in60   = d[19:10];
        f.hypo   = d[26:20];
        f.hyper  = d[33:27];
        f.fused  = d[40:34];
        f.advice = gtfr_pkg::t_advice'(d[43:41]);
        return f;
    endfunction

    // advances the trend window and works out the forecast for one reading
    function automatic t_forecast forecast_next(input t_reading r);
        int g, t, iob, cob, hr, act, n, p30, p60, hypo, hyper, fused;
        t_forecast f;
        g   = r.glucose;
        t   = r.trend;
        iob = r.insulin;
        cob = r.carbs;
        hr  = r.heart;
        act = r.activity;

        trend_total = trend_total - trend_hist[hist_slot] + t;
        trend_hist[hist_slot] = t;
        hist_slot = (hist_slot + 1 >= gtfr_pkg::TREND_WINDOW) ? 0 : hist_slot + 1;
        if (readings < gtfr_pkg::TREND_WINDOW + 1)
            readings++;

        if (readings < 2) begin
            f.in30   = r.glucose;
            f.in60   = r.glucose;
            f.hypo   = '0;
            f.hyper  = '0;
            f.fused  = '0;
            f.advice = gtfr_pkg::ADV_NONE;
            return f;
        end

        n   = (readings < gtfr_pkg::TREND_WINDOW) ? readings : gtfr_pkg::TREND_WINDOW;
        p30 = g * 100 + (trend_total * 30) / n - (iob * 9) / 4 + cob * 10;
        p60 = g * 100 + (trend_total * 60) / n - iob * 9 + cob * 20;
        // activity only counts with a known heart rate
        if (act > 0 && hr > 0) begin
            p30 -= act * 30;
            p60 -= act * 60;
        end
        p30 = (p30 < 3000) ? 3000 : (p30 > 40000) ? 40000 : p30;
        p60 = (p60 < 3000) ? 3000 : (p60 > 40000) ? 40000 : p60;

        if (p30 < 7000)      hypo = 95;
        else if (p30 < 8000) hypo = (9000 - (p30 - 7000) * 8) / 100;
        else if (p30 < 9000) hypo = (3000 - (p30 - 8000) * 3) / 100;
        else                 hypo = 0;

        if (p60 > 25000)      hyper = 90;
        else if (p60 > 18000) hyper = (80000 - (25000 - p60) * 8) / 1000;
        else if (p60 > 16000) hyper = (p60 - 16000) / 100;
        else                  hyper = 0;

        if (hypo > 50)       fused = hypo;
        else if (hyper > 50) fused = (hyper * 8) / 10;
        else if (g < 70)     fused = 80;
        else if (g < 80)     fused = 40;
        else if (g > 250)    fused = 70;
        else if (g > 180)    fused = 30;
        else                 fused = 10;

        if (hypo > 70)       f.advice = gtfr_pkg::ADV_SNACK;
        else if (hyper > 60) f.advice = gtfr_pkg::ADV_INSULIN;
        else if (fused > 50) f.advice = gtfr_pkg::ADV_CHECK;
        else if (fused > 20) f.advice = gtfr_pkg::ADV_MONITOR;
        else                 f.advice = gtfr_pkg::ADV_NONE;

        f.in30  = 10'(p30 / 100);
        f.in60  = 10'(p60 / 100);
        f.hypo  = 7'(hypo);
        f.hyper = 7'(hyper);
        f.fused = 7'(fused);
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result(input t_forecast got);
        t_forecast want;
        if (forecast_q.size() == 0) begin
            report_mismatch($sformatf("result beat with no reading waiting (%0d %0d)",
                                      got.in30, got.in60));
            return;
        end
        want = forecast_q.pop_front();
        if (got.in30 !== want.in30)
            report_mismatch($sformatf("glucose_in_30 %0d, want %0d", got.in30, want.in30));
        if (got.in60 !== want.in60)
            report_mismatch($sformatf("glucose_in_60 %0d, want %0d", got.in60, want.in60));
        if (got.hypo !== want.hypo)
            report_mismatch($sformatf("hypo_risk %0d, want %0d", got.hypo, want.hypo));
        if (got.hyper !== want.hyper)
            report_mismatch($sformatf("hyper_risk %0d, want %0d", got.hyper, want.hyper));
        if (got.fused !== want.fused)
            report_mismatch($sformatf("fused_risk %0d, want %0d", got.fused, want.fused));
        if (got.advice !== want.advice)
            report_mismatch($sformatf("advice_code %0d, want %0d", got.advice, want.advice));
    endtask

    task automatic add_row(input int g, t, iob, cob, hr, act, input bit typed = 1'b0,
                           input int o30 = 0, o60 = 0, hy = 0, hp = 0, fu = 0,
                           input gtfr_pkg::t_advice adv = gtfr_pkg::ADV_NONE);
        t_stim_row row;
        row.rd.glucose     = 10'(g);
        row.rd.trend       = 13'(t);
        row.rd.insulin     = 13'(iob);
        row.rd.carbs       = 11'(cob);
        row.rd.heart       = 8'(hr);
        row.rd.activity    = 8'(act);
        row.typed          = typed;
        row.want.in30      = 10'(o30);
        row.want.in60      = 10'(o60);
        row.want.hypo      = 7'(hy);
        row.want.hyper     = 7'(hp);
        row.want.fused     = 7'(fu);
        row.want.advice    = adv;
        directed_rows.push_back(row);
    endtask

    function automatic t_reading random_reading();
        t_reading r;
        if ($urandom_range(0, 3) == 0) begin
            // anything the fields can carry
            r.glucose  = 10'($urandom);
            r.trend    = 13'($urandom);
            r.insulin  = 13'($urandom);
            r.carbs    = 11'($urandom);
            r.heart    = 8'($urandom);
            r.activity = 8'($urandom);
        end else begin
            r.glucose  = 10'($urandom_range(40, 400));
            r.trend    = 13'(int'($urandom_range(0, 800)) - 400);
            r.insulin  = 13'($urandom_range(0, 5000));
            r.carbs    = 11'($urandom_range(0, 2000));
            r.heart    = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(45, 190));
            r.activity = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 120));
        end
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_reading(input t_reading r, input bit typed, input t_forecast want);
        t_forecast pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_reading(r);
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pred = forecast_next(r);
        if (typed)
            forecast_q.push_back(want);
        else
            forecast_q.push_back(pred);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result(unpack_forecast(m_axis_tdata));
    end

    // ends the run when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_forecast none;
        none = '{default: '0, advice: gtfr_pkg::ADV_NONE};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first reading passes straight through
        add_row(120, 0, 0, 0, 0, 0, 1'b1, 120, 120, 0, 0, 0, gtfr_pkg::ADV_NONE);
        // top extremes clamp at 400
        add_row(1023, 4095, 0, 2047, 255, 0, 1'b1, 400, 400, 0, 90, 72, gtfr_pkg::ADV_INSULIN);
        add_row(1023, 4095, 0, 2047, 255, 0, 1'b1, 400, 400, 0, 90, 72, gtfr_pkg::ADV_INSULIN);
        // unknown heart rate, activity ignored
        add_row(1023, 4095, 0, 2047, 0, 255, 1'b1, 400, 400, 0, 90, 72, gtfr_pkg::ADV_INSULIN);
        // bottom extremes, the last one with a full window of falling trends
        add_row(0, -4096, 8191, 0, 255, 255);
        add_row(0, -4096, 8191, 0, 255, 255);
        add_row(0, -4096, 8191, 0, 255, 255);
        add_row(0, -4096, 8191, 0, 255, 255);
        add_row(0, -4096, 8191, 0, 255, 255, 1'b1, 30, 30, 95, 0, 95, gtfr_pkg::ADV_SNACK);
        // flush the window with flat trends
        repeat (5) add_row(100, 0, 0, 0, 70, 0);
        // hypo and hyper ramps and the fused branches on the reading
        add_row(75, 0, 0, 0, 70, 0);
        add_row(85, 0, 0, 0, 70, 0);
        add_row(65, 0, 0, 0, 70, 0);
        add_row(170, 0, 0, 0, 70, 0);
        add_row(210, 0, 0, 0, 70, 0);
        add_row(240, 0, 0, 0, 70, 0);
        add_row(300, 0, 0, 0, 70, 0);
        add_row(260, 0, 4000, 0, 70, 0);
        add_row(200, 0, 4000, 0, 70, 0);
        // insulin and carbs beyond their usual range
        add_row(100, 0, 8191, 2047, 0, 255);
        add_row(180, -4096, 0, 0, 120, 200);
        add_row(1023, 4095, 5000, 0, 1, 1);

        foreach (directed_rows[i])
            send_reading(directed_rows[i].rd, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_by_phase[ph];
            recv_stall_pct = stall_by_phase[ph];
            repeat (RANDOM_ITEMS / 4)
                send_reading(random_reading(), 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (forecast_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/gtfr_pkg.sv
sv/gtfr_window.sv
sv/gtfr_mul.sv
sv/gtfr_ctrl.sv
sv/glucose_trend_forecast_risk_core.sv
sv/gtfr_checker.sv
tb/testbench.sv
